### design/prrs_pkg.sv
// types and constants shared by the process slot scheduler modules
// no dependencies; imported by the controller, the datapath and the top level
package prrs_pkg;

   // command codes
   localparam logic [1:0] CMD_CREATE   = 2'd0;
   localparam logic [1:0] CMD_DESTROY  = 2'd1;
   localparam logic [1:0] CMD_SCHEDULE = 2'd2;

   // slot state codes
   localparam logic [1:0] SLOT_FREE    = 2'd0;
   localparam logic [1:0] SLOT_READY   = 2'd1;
   localparam logic [1:0] SLOT_RUNNING = 2'd2;
   localparam logic [1:0] SLOT_IDLE    = 2'd3;

   // result status codes
   localparam logic [2:0] STAT_DONE  = 3'd0;
   localparam logic [2:0] STAT_FULL  = 3'd1;
   localparam logic [2:0] STAT_EMPTY = 3'd2;
   localparam logic [2:0] STAT_KEEP  = 3'd3;
   localparam logic [2:0] STAT_IDLE  = 3'd4;

   // input transaction
   typedef struct packed {
      logic [1:0] command;
      logic [7:0] slot_index;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] pid_out;
      logic       first_dispatch;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear;
      logic load;
      logic read_one;
      logic capture;
      logic scan_init;
      logic scan;
      logic demote;
      logic finish;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [1:0] op;
      logic       clear_last;
      logic       scan_done;
   } ctl_status_type;

endpackage

### design/prrs_ctrl.sv
// sequencer for the process slot scheduler: clearing pass, reads, scan, demote, commit
// depends on prrs_pkg
module prrs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    out_free,
   input  prrs_pkg::ctl_status_type status,
   output prrs_pkg::ctl_cmd_type    cmd,
   output logic                    idle
);
   import prrs_pkg::*;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DISPATCH = 3'd2;
   localparam logic [2:0] S_WAIT     = 3'd3;
   localparam logic [2:0] S_SCAN     = 3'd4;
   localparam logic [2:0] S_DEMOTE   = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.op)
               CMD_CREATE: begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
               CMD_DESTROY, CMD_SCHEDULE: begin
                  cmd.read_one = 1'b1;
                  state_in     = S_WAIT;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_WAIT: begin
            cmd.capture = 1'b1;
            if (status.op == CMD_SCHEDULE) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_DEMOTE;
            end
         end
         S_DEMOTE: begin
            cmd.demote = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == S_IDLE);

endmodule

### design/prrs_datapath.sv
// slot table memory, scan counters, current task registers and result logic
// depends on prrs_pkg
module prrs_datapath #(
   parameter int SLOTS = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  prrs_pkg::req_type        req_data,
   input  prrs_pkg::ctl_cmd_type    cmd,
   output prrs_pkg::ctl_status_type status,
   output prrs_pkg::rsp_type        result
);
   import prrs_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
   localparam logic [CW-1:0] SCAN_LEN  = CW'(SLOTS);

   // slot table
   logic [1:0]    slot_mem_ff [SLOTS];
   logic [1:0]    rd_data_ff;
   logic [SW-1:0] rd_addr;
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   logic [1:0]    wr_data;

   // latched transaction
   logic [1:0]    op_ff;
   logic [7:0]    idx_ff;

   // current task
   logic [SW-1:0] cur_slot_ff, cur_slot_in;
   logic          has_cur_ff, has_cur_in;
   logic          cur_live_ff, cur_live_in;
   logic [1:0]    tgt_state_ff;

   // scan pipeline
   logic [SW-1:0] addr_ff, addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] chk_addr_ff;
   logic          chk_valid_ff, chk_valid_in;
   logic          found_ff, found_in;
   logic [SW-1:0] found_addr_ff;

   logic [SW-1:0] one_addr;
   logic [SW-1:0] scan_start;
   logic [1:0]    scan_target;
   logic          scan_issue;
   logic          hit;
   logic          live;
   logic          in_range;
   logic [SW-1:0] idx_slot;

   assign idx_slot    = SW'(idx_ff);
   assign in_range    = ({24'd0, idx_ff} < 32'(SLOTS));
   assign live        = has_cur_ff && cur_live_ff;
   assign one_addr    = (op_ff == CMD_DESTROY) ? idx_slot : cur_slot_ff;
   // create looks for the lowest free slot, schedule starts after the current one (slot 0 if none)
   assign scan_start  = (op_ff == CMD_CREATE || !has_cur_ff) ? '0 :
                        (cur_slot_ff == LAST_SLOT) ? '0 : cur_slot_ff + SW'(1);
   assign scan_target = (op_ff == CMD_CREATE) ? SLOT_FREE : SLOT_READY;
   assign scan_issue  = cmd.scan && (cnt_ff != SCAN_LEN);
   assign hit         = chk_valid_ff && (rd_data_ff == scan_target);
   assign rd_addr     = cmd.read_one ? one_addr : addr_ff;

   // status to the controller
   assign status.op         = op_ff;
   assign status.clear_last = (addr_ff == LAST_SLOT);
   assign status.scan_done  = hit || ((cnt_ff == SCAN_LEN) && !chk_valid_ff);

   // sweep address and scan bookkeeping
   always_comb begin
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      chk_valid_in = scan_issue;
      found_in     = found_ff;
      if (cmd.scan_init) begin
         addr_in  = scan_start;
         cnt_in   = '0;
         found_in = 1'b0;
      end else if (cmd.clear || scan_issue) begin
         addr_in = (addr_ff == LAST_SLOT) ? '0 : addr_ff + SW'(1);
         cnt_in  = cnt_ff + CW'(1);
      end
      if (cmd.scan && hit) begin
         found_in = 1'b1;
      end
   end

   // memory write, current task update and result
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_data     = SLOT_FREE;
      cur_slot_in = cur_slot_ff;
      has_cur_in  = has_cur_ff;
      cur_live_in = cur_live_ff;
      result      = '0;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.demote) begin
         // running current task goes back to ready before the switch
         if (op_ff == CMD_SCHEDULE && found_ff && live && tgt_state_ff == SLOT_RUNNING) begin
            wr_en   = 1'b1;
            wr_addr = cur_slot_ff;
            wr_data = SLOT_READY;
         end
      end else if (cmd.finish) begin
         case (op_ff)
            CMD_CREATE: begin
               if (found_ff) begin
                  wr_en          = 1'b1;
                  wr_addr        = found_addr_ff;
                  wr_data        = SLOT_READY;
                  result.status  = STAT_DONE;
                  result.pid_out = 8'(found_addr_ff);
               end else begin
                  result.status = STAT_FULL;
               end
            end
            CMD_DESTROY: begin
               result.pid_out = idx_ff;
               if (in_range && tgt_state_ff != SLOT_FREE) begin
                  wr_en         = 1'b1;
                  wr_addr       = idx_slot;
                  wr_data       = SLOT_FREE;
                  result.status = STAT_DONE;
                  if (live && cur_slot_ff == idx_slot) begin
                     cur_live_in = 1'b0;
                  end
               end else begin
                  result.status = STAT_EMPTY;
               end
            end
            CMD_SCHEDULE: begin
               if (found_ff) begin
                  wr_en                 = 1'b1;
                  wr_addr               = found_addr_ff;
                  wr_data               = SLOT_RUNNING;
                  cur_slot_in           = found_addr_ff;
                  has_cur_in            = 1'b1;
                  cur_live_in           = 1'b1;
                  result.status         = STAT_DONE;
                  result.pid_out        = 8'(found_addr_ff);
                  result.first_dispatch = !has_cur_ff;
               end else if (live && (tgt_state_ff == SLOT_RUNNING ||
                                     tgt_state_ff == SLOT_READY)) begin
                  wr_en          = 1'b1;
                  wr_addr        = cur_slot_ff;
                  wr_data        = SLOT_RUNNING;
                  result.status  = STAT_KEEP;
                  result.pid_out = 8'(cur_slot_ff);
               end else begin
                  // current slot is zero while no task was ever current
                  wr_en          = live;
                  wr_addr        = cur_slot_ff;
                  wr_data        = SLOT_IDLE;
                  result.status  = STAT_IDLE;
                  result.pid_out = 8'(cur_slot_ff);
               end
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

   // slot table port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.command;
         idx_ff <= req_data.slot_index;
      end
      if (cmd.capture) begin
         tgt_state_ff <= rd_data_ff;
      end
      if (cmd.scan && hit && !found_ff) begin
         found_addr_ff <= chk_addr_ff;
      end
      chk_addr_ff <= addr_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         cnt_ff       <= '0;
         chk_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         cur_slot_ff  <= '0;
         has_cur_ff   <= 1'b0;
         cur_live_ff  <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         chk_valid_ff <= chk_valid_in;
         found_ff     <= found_in;
         cur_slot_ff  <= cur_slot_in;
         has_cur_ff   <= has_cur_in;
         cur_live_ff  <= cur_live_in;
      end
   end

endmodule

### design/process_slot_round_robin_scheduler_unit.sv
// top level of the process slot round robin scheduler
// depends on prrs_pkg, prrs_ctrl and prrs_datapath
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+-----------------------------
//   request  | req_valid, req_stall, req_data | command and slot index
//   response | rsp_valid, rsp_stall, rsp_data | status, pid and first flag
//
// one transaction at a time; create and schedule scan the slot table, which
// reads one slot per cycle through the single memory read port, while
// destroy reads only its one slot. after reset a clearing pass writes every
// slot free with req_stall high. a result waits in the output register
// under rsp_stall; the next request is taken while it waits.
module process_slot_round_robin_scheduler_unit #(
   parameter int SLOTS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  prrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output prrs_pkg::rsp_type rsp_data
);
   import prrs_pkg::*;

   ctl_cmd_type    ctl_cmd;
   ctl_status_type ctl_status;
   rsp_type        result;
   logic           ctl_idle;
   logic           out_free;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !ctl_idle;

   prrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .status    (ctl_status),
      .cmd       (ctl_cmd),
      .idle      (ctl_idle)
   );

   prrs_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (ctl_cmd),
      .status   (ctl_status),
      .result   (result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl_cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.finish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.finish |-> out_free)
      else $error("result committed while output register held");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous transaction in flight");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.finish |=> rsp_valid)
      else $error("committed result not presented");

   a_first_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.first_dispatch) |-> (rsp_data.status == STAT_DONE))
      else $error("first dispatch flagged on a non-dispatch result");

endmodule

### verif/slot_table_checker.sv
`timescale 1ns / 100ps
// checker for the process slot round robin scheduler: keeps its own slot table,
// predicts every response from the accepted requests and compares field by field
// depends on prrs_pkg for the transaction types and the command and status codes
module slot_table_checker #(
   parameter int SLOTS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  prrs_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  prrs_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                awaited_count
);
   import prrs_pkg::*;

   // shadow of the scheduler state
   logic [1:0]  slot_tab [SLOTS];
   int unsigned cur_slot;
   bit          has_cur;
   bit          cur_live;

   // responses still owed by the block, oldest first
   rsp_type     owed_rsp_q [$];

   initial error_count = 0;
   initial awaited_count = 0;

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s, got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // apply one command to the shadow table and work out its response
   task automatic run_table_command(input req_type cmd_in, output rsp_type res);
      int unsigned idx;
      int unsigned start;
      int unsigned probe;
      int unsigned pick;
      bit          found;
      bit          live;
      res   = '0;
      found = 1'b0;
      pick  = 0;
      idx   = 32'(cmd_in.slot_index);
      case (cmd_in.command)
         CMD_CREATE: begin
            // lowest free slot becomes ready
            res.status = STAT_FULL;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && slot_tab[i] == SLOT_FREE) begin
                  slot_tab[i] = SLOT_READY;
                  res.status  = STAT_DONE;
                  res.pid_out = i[7:0];
                  found       = 1'b1;
               end
            end
         end
         CMD_DESTROY: begin
            res.pid_out = cmd_in.slot_index;
            if (idx >= SLOTS || slot_tab[idx] == SLOT_FREE) begin
               res.status = STAT_EMPTY;
            end else begin
               slot_tab[idx] = SLOT_FREE;
               // current slot number stays as the round robin start point
               if (has_cur && cur_live && cur_slot == idx)
                  cur_live = 1'b0;
               res.status = STAT_DONE;
            end
         end
         CMD_SCHEDULE: begin
            start = has_cur ? (cur_slot + 1) % SLOTS : 0;
            live  = has_cur && cur_live;
            for (int i = 0; i < SLOTS; i++) begin
               probe = (start + i) % SLOTS;
               if (!found && slot_tab[probe] == SLOT_READY) begin
                  pick  = probe;
                  found = 1'b1;
               end
            end
            if (!found) begin
               if (live && (slot_tab[cur_slot] == SLOT_RUNNING ||
                            slot_tab[cur_slot] == SLOT_READY)) begin
                  slot_tab[cur_slot] = SLOT_RUNNING;
                  res.status  = STAT_KEEP;
                  res.pid_out = cur_slot[7:0];
               end else begin
                  if (live)
                     slot_tab[cur_slot] = SLOT_IDLE;
                  res.status  = STAT_IDLE;
                  res.pid_out = has_cur ? cur_slot[7:0] : 8'd0;
               end
            end else begin
               // running current task goes back to ready
               if (live && slot_tab[cur_slot] == SLOT_RUNNING)
                  slot_tab[cur_slot] = SLOT_READY;
               slot_tab[pick]     = SLOT_RUNNING;
               res.status         = STAT_DONE;
               res.pid_out        = pick[7:0];
               res.first_dispatch = !has_cur;
               cur_slot           = pick;
               has_cur            = 1'b1;
               cur_live           = 1'b1;
            end
         end
         default: begin
            // unused command code leaves everything alone
            res = '0;
         end
      endcase
   endtask

   // watch both channels at the rising edge
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type pred;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            slot_tab[i] = SLOT_FREE;
         cur_slot = 0;
         has_cur  = 1'b0;
         cur_live = 1'b0;
         owed_rsp_q.delete();
      end else begin
         // response transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp_q.size() == 0) begin
               flag_mismatch("response with nothing awaited, pid", rsp_data.pid_out, -1);
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_data.status !== want.status)
                  flag_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.pid_out !== want.pid_out)
                  flag_mismatch("pid_out", rsp_data.pid_out, want.pid_out);
               if (rsp_data.first_dispatch !== want.first_dispatch)
                  flag_mismatch("first_dispatch", rsp_data.first_dispatch,
                                want.first_dispatch);
            end
         end
         // request transaction updates the shadow table
         if (req_valid && !req_stall) begin
            run_table_command(req_data, pred);
            owed_rsp_q.push_back(pred);
         end
      end
      awaited_count = owed_rsp_q.size();
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// top of the process slot scheduler testbench: clock, reset, request stimulus,
// response stalls, watchdog and verdict; depends on prrs_pkg, the scheduler unit
// and slot_table_checker, which does all prediction and comparison
module testbench;
   import prrs_pkg::*;

   localparam int SLOTS        = 256;
   localparam int ITEM_TARGET  = 1400;
   localparam int HOLD_CYCLES  = 1500;
   localparam int QUIET_LIMIT  = 8000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 20;

   // command code the block does not define
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   // traffic mixes of the random part
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} traffic_mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      error_count;
   int      awaited_count;

   int      quiet_cycles  = 0;
   int      burst_left    = 0;
   bit      steady_sender = 1'b0;
   int      occupancy_est = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   process_slot_round_robin_scheduler_unit #(
      .SLOTS(SLOTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   slot_table_checker #(
      .SLOTS(SLOTS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .error_count  (error_count),
      .awaited_count(awaited_count)
   );

   // offer one request transaction, called at a falling edge
   task automatic send_transaction(input logic [1:0] cmd, input logic [7:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = steady_sender ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_data.command    = cmd;
      req_data.slot_index = idx;
      req_valid           = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
      if (cmd == CMD_CREATE && occupancy_est < SLOTS)
         occupancy_est++;
      if (cmd == CMD_DESTROY && occupancy_est > 0)
         occupancy_est--;
   endtask

   // request stimulus and verdict
   initial begin : stimulus
      traffic_mix_type mix;
      int              seg_len;
      int              counted;
      int              roll;
      int              occ_hi;
      logic [1:0]      cmd;
      logic [7:0]      idx;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, extremes, first dispatch, round robin,
      // destroy of the current task, slot reuse and the unused command
      send_transaction(CMD_SCHEDULE, 8'h00);
      send_transaction(CMD_DESTROY,  8'h00);
      send_transaction(CMD_DESTROY,  8'hFF);
      send_transaction(CMD_RESERVED, 8'hFF);
      send_transaction(CMD_CREATE,   8'hFF);
      send_transaction(CMD_CREATE,   8'h00);
      send_transaction(CMD_CREATE,   8'hAA);
      send_transaction(CMD_SCHEDULE, 8'h55);
      send_transaction(CMD_SCHEDULE, 8'h00);
      send_transaction(CMD_DESTROY,  8'h02);
      send_transaction(CMD_DESTROY,  8'h01);
      send_transaction(CMD_SCHEDULE, 8'h00);
      send_transaction(CMD_SCHEDULE, 8'hFF);
      send_transaction(CMD_DESTROY,  8'h00);
      send_transaction(CMD_SCHEDULE, 8'h00);
      send_transaction(CMD_CREATE,   8'h00);
      send_transaction(CMD_SCHEDULE, 8'h00);
      send_transaction(CMD_SCHEDULE, 8'h00);
      send_transaction(CMD_DESTROY,  8'h80);

      // random: a long fill first so the table runs full, then mixed segments
      counted = 0;
      mix     = MIX_FILL;
      seg_len = 340;
      while (counted < ITEM_TARGET) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            roll = $urandom_range(0, 99);
            case (mix)
               MIX_FILL:
                  cmd = (roll < 85) ? CMD_CREATE : (roll < 95) ? CMD_SCHEDULE : CMD_DESTROY;
               MIX_DRAIN:
                  cmd = (roll < 65) ? CMD_DESTROY : (roll < 90) ? CMD_SCHEDULE : CMD_CREATE;
               default:
                  cmd = (roll < 30) ? CMD_CREATE : (roll < 58) ? CMD_DESTROY :
                        (roll < 96) ? CMD_SCHEDULE : CMD_RESERVED;
            endcase
            // destroys mostly aim at the occupied low end of the table
            occ_hi = (occupancy_est + 4 > 255) ? 255 : occupancy_est + 4;
            if (cmd == CMD_DESTROY && $urandom_range(0, 3) != 0)
               idx = 8'($urandom_range(0, occ_hi));
            else
               idx = 8'($urandom_range(0, 255));
            send_transaction(cmd, idx);
            if (cmd != CMD_RESERVED)
               counted++;
         end
         case ($urandom_range(0, 2))
            0:       mix = MIX_FILL;
            1:       mix = MIX_DRAIN;
            default: mix = MIX_BLEND;
         endcase
         seg_len = $urandom_range(40, 160);
      end
      req_valid = 1'b0;

      // wait for every awaited response, then let the block settle
      while (awaited_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && awaited_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // response stalls: random phases, with a long hold-off now and then
   initial begin : receiver
      int phase_no;
      int phase_len;
      int stall_pct;
      bit held_last;
      phase_no  = 0;
      held_last = 1'b0;
      forever begin
         if (!held_last && (phase_no == 2 || $urandom_range(0, 59) == 0)) begin
            // long hold-off so the block fills and stalls its input
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            held_last = 1'b1;
         end else begin
            phase_len = $urandom_range(30, 300);
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 20;
               2:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
            repeat (phase_len) begin
               rsp_stall = ($urandom_range(0, 99) < stall_pct);
               @(negedge clock);
            end
            held_last = 1'b0;
         end
         phase_no++;
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule
